// ===== sv/cpd_pkg.sv =====
// Shared types and constants of the convolution peak detector.
`default_nettype none
package cpd_pkg;
  localparam int OUT_W = 30;
  localparam int MAG_W = 2 * OUT_W;
  localparam int IDX_W = 6;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] TAP_COUNT_RST = 7'd64;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FEED = 1'b1;

  typedef struct packed {
    logic tap_wr;
    logic step;
    logic zero;
    logic report;
    logic clear;
    logic drop;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic out_full;
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/cpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/cpd_datapath.sv =====
// Datapath: delay line, tap RAM, complex MAC, peak tracking and result register.
`default_nettype none
module cpd_datapath import cpd_pkg::*; #(
  parameter int TAPS = 64,
  parameter int SB = 12,
  parameter int POS_W = 17
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire cmd_t                       cmd,
  input  wire logic [$clog2(TAPS+1)-1:0]  m,
  input  wire logic [IDX_W-1:0]           tap_idx,
  input  wire logic signed [SB-1:0]       val_re,
  input  wire logic signed [SB-1:0]       val_im,
  input  wire logic                       out_ready,
  output sts_t                            sts,
  output logic [POS_W-1:0]                out_idx,
  output logic signed [OUT_W-1:0]         out_re,
  output logic signed [OUT_W-1:0]         out_im,
  output logic                            out_ovf
);
  localparam int AW = $clog2(TAPS);
  localparam int CYW = $clog2(TAPS + 5);
  localparam int ACC_W = 2 * SB + 2 + $clog2(TAPS);
  localparam int EW = (ACC_W > OUT_W) ? ACC_W : OUT_W;
  localparam logic signed [EW-1:0] SAT_MAX = EW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] SAT_MIN = EW'(-(64'sd1 <<< (OUT_W - 1)));

  logic signed [SB-1:0] hre_r [TAPS];
  logic signed [SB-1:0] him_r [TAPS];
  logic                 busy_r, done_r;
  logic [CYW-1:0]       cyc_r;
  logic                 v0_r, e0_r, v1_r;
  logic signed [SB-1:0] x0re_r, x0im_r;
  logic signed [2*SB-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  logic signed [OUT_W-1:0] sat_re_r, sat_im_r;
  logic [MAG_W-1:0]     sq_re_r, sq_im_r;
  logic [MAG_W-1:0]     best_mag_r;
  logic signed [OUT_W-1:0] best_re_r, best_im_r;
  logic [POS_W-1:0]     best_pos_r, pos_r;
  logic                 out_valid_r;
  logic [2*SB-1:0]      ram_q;
  logic signed [SB-1:0] h_re, h_im;
  logic signed [EW-1:0] ext_re, ext_im;
  logic [MAG_W-1:0]     mag;
  logic                 rot;

  cpd_ram #(.WIDTH(2 * SB), .DEPTH(TAPS)) u_taps (
    .clk   (clk),
    .we    (cmd.tap_wr && (32'(tap_idx) < TAPS)),
    .waddr (AW'(tap_idx)),
    .wdata ({val_im, val_re}),
    .raddr (cyc_r[AW-1:0]),
    .rdata (ram_q)
  );

  assign h_re   = ram_q[SB-1:0];
  assign h_im   = ram_q[2*SB-1:SB];
  assign ext_re = EW'(acc_re_r);
  assign ext_im = EW'(acc_im_r);
  assign mag    = sq_re_r + sq_im_r;
  assign rot    = busy_r && (32'(cyc_r) < TAPS);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < TAPS; i++) begin
        hre_r[i] <= '0;
        him_r[i] <= '0;
      end
    end else if (cmd.step) begin
      hre_r[0] <= cmd.zero ? '0 : val_re;
      him_r[0] <= cmd.zero ? '0 : val_im;
      for (int i = 1; i < TAPS; i++) begin
        hre_r[i] <= hre_r[i-1];
        him_r[i] <= him_r[i-1];
      end
    end else if (rot) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        hre_r[i] <= hre_r[i+1];
        him_r[i] <= him_r[i+1];
      end
      hre_r[TAPS-1] <= hre_r[0];
      him_r[TAPS-1] <= him_r[0];
    end
  end

  always_ff @(posedge clk) begin
    x0re_r <= hre_r[0];
    x0im_r <= him_r[0];
    e0_r   <= (32'(cyc_r) < 32'(m));
    p_rr_r <= x0re_r * h_re;
    p_ii_r <= x0im_r * h_im;
    p_ri_r <= x0re_r * h_im;
    p_ir_r <= x0im_r * h_re;
    if (32'(cyc_r) == TAPS + 2) begin
      sat_re_r <= (ext_re > SAT_MAX) ? OUT_W'(SAT_MAX) :
                  (ext_re < SAT_MIN) ? OUT_W'(SAT_MIN) : OUT_W'(ext_re);
      sat_im_r <= (ext_im > SAT_MAX) ? OUT_W'(SAT_MAX) :
                  (ext_im < SAT_MIN) ? OUT_W'(SAT_MIN) : OUT_W'(ext_im);
    end
    if (32'(cyc_r) == TAPS + 3) begin
      sq_re_r <= MAG_W'(sat_re_r * sat_re_r);
      sq_im_r <= MAG_W'(sat_im_r * sat_im_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      done_r      <= 1'b0;
      cyc_r       <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      best_mag_r  <= '0;
      best_re_r   <= '0;
      best_im_r   <= '0;
      best_pos_r  <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      v0_r   <= rot;
      v1_r   <= v0_r && e0_r;
      if (cmd.step) begin
        busy_r   <= 1'b1;
        cyc_r    <= '0;
        acc_re_r <= '0;
        acc_im_r <= '0;
      end else if (busy_r) begin
        cyc_r <= cyc_r + 1'b1;
        if (v1_r) begin
          acc_re_r <= acc_re_r + ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
          acc_im_r <= acc_im_r + ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
        end
        if (32'(cyc_r) == TAPS + 4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          pos_r  <= pos_r + 1'b1;
          if (mag > best_mag_r) begin
            best_mag_r <= mag;
            best_re_r  <= sat_re_r;
            best_im_r  <= sat_im_r;
            best_pos_r <= pos_r;
          end
        end
      end
      if (cmd.report) begin
        out_valid_r <= 1'b1;
        out_idx     <= best_pos_r;
        out_re      <= best_re_r;
        out_im      <= best_im_r;
        out_ovf     <= cmd.drop;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.clear) begin
        best_mag_r <= '0;
        best_re_r  <= '0;
        best_im_r  <= '0;
        best_pos_r <= '0;
        pos_r      <= '0;
      end
    end
  end

  assign sts.busy     = busy_r;
  assign sts.done     = done_r;
  assign sts.out_full = out_valid_r;
endmodule
`default_nettype wire

// ===== sv/cpd_ctrl.sv =====
// Controller: sequences tap loads, sample steps, tail flush and result report.
`default_nettype none
module cpd_ctrl import cpd_pkg::*; #(
  parameter int TAPS = 64,
  parameter int MAX_SAMPLES = 65536
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_kind,
  input  wire logic                      in_last,
  input  wire logic [$clog2(TAPS+1)-1:0] m,
  input  wire sts_t                      sts,
  output logic                           in_ready,
  output cmd_t                           cmd
);
  localparam int MW = $clog2(TAPS + 1);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH, S_REPORT} state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [MW-1:0]  flush_r, flush_nxt;
  logic           last_r, last_nxt;
  logic           drop_r, drop_nxt;
  logic           more_taps;
  logic           more_flush;

  assign more_taps  = (m > MW'(1));
  assign more_flush = (({1'b0, flush_r} + 1'b1) < {1'b0, m});
  assign in_ready   = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    flush_nxt = flush_r;
    last_nxt  = last_r;
    drop_nxt  = drop_r;
    cmd       = '0;
    cmd.drop  = drop_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == CMD_LOAD) begin
            cmd.tap_wr = 1'b1;
          end else if (cnt_r < CW'(MAX_SAMPLES)) begin
            cnt_nxt   = cnt_r + 1'b1;
            cmd.step  = 1'b1;
            last_nxt  = in_last;
            state_nxt = S_RUN;
          end else begin
            drop_nxt = 1'b1;
            if (in_last) begin
              flush_nxt = MW'(1);
              if (more_taps) begin
                cmd.step  = 1'b1;
                cmd.zero  = 1'b1;
                state_nxt = S_FLUSH;
              end else begin
                state_nxt = S_REPORT;
              end
            end
          end
        end
      end
      S_RUN: begin
        if (sts.done) begin
          if (last_r) begin
            flush_nxt = MW'(1);
            if (more_taps) begin
              cmd.step  = 1'b1;
              cmd.zero  = 1'b1;
              state_nxt = S_FLUSH;
            end else begin
              state_nxt = S_REPORT;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (sts.done) begin
          if (more_flush) begin
            flush_nxt = flush_r + 1'b1;
            cmd.step  = 1'b1;
            cmd.zero  = 1'b1;
          end else begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_REPORT: begin
        if (!sts.out_full) begin
          cmd.report = 1'b1;
          cmd.clear  = 1'b1;
          cnt_nxt    = '0;
          drop_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      flush_r <= '0;
      last_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flush_r <= flush_nxt;
      last_r  <= last_nxt;
      drop_r  <= drop_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/convolution_peak_detector.sv =====
// Top level: matched-filter convolution with peak detection over a frame.
// Tap load: loads can follow back to back. After a sample transfer no further input is
// accepted until that sample is done, whatever tap_count is: the shared complex MAC runs
// over the whole delay line and tap RAM, then come the product, accumulate, saturate, square
// and compare stages, and a return to idle. A last sample adds m-1 flush outputs, m being
// tap_count clamped to 1..TAPS; the result is loaded from the report state after the final
// compare once the output register is free. Synchronous active-low reset clears the delay
// line, peak and counters at once; tap_count resets to 64.
`default_nettype none
module convolution_peak_detector import cpd_pkg::*; #(
  parameter int TAPS = 64,
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // tap_index, value_re, value_im, zero fill
  input  wire logic [((IDX_W+2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // command
  input  wire logic in_tuser,
  input  wire logic in_tlast,
  output logic      out_tvalid,
  input  wire logic out_tready,
  // peak_index, peak_re, peak_im, zero fill
  output logic [(($clog2(MAX_SAMPLES+TAPS)+2*OUT_W+7)/8)*8-1:0] out_tdata,
  // overflow
  output logic      out_tuser
);
  localparam int MW = $clog2(TAPS + 1);
  localparam int POS_W = $clog2(MAX_SAMPLES + TAPS);
  localparam int OD_W = ((POS_W + 2 * OUT_W + 7) / 8) * 8;

  logic [CFG_W-1:0] tap_count_r;
  logic [MW-1:0]    m;
  cmd_t             cmd;
  sts_t             sts;
  logic [POS_W-1:0] out_idx;
  logic signed [OUT_W-1:0] out_re, out_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_we) begin
      tap_count_r <= cfg_wdata;
    end
  end

  assign m = (tap_count_r == '0) ? MW'(1) :
             (32'(tap_count_r) > TAPS) ? MW'(TAPS) : MW'(tap_count_r);

  cpd_ctrl #(.TAPS(TAPS), .MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_last  (in_tlast),
    .m        (m),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  cpd_datapath #(.TAPS(TAPS), .SB(SAMPLE_BITS), .POS_W(POS_W)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .m         (m),
    .tap_idx   (in_tdata[IDX_W-1:0]),
    .val_re    (in_tdata[IDX_W +: SAMPLE_BITS]),
    .val_im    (in_tdata[IDX_W+SAMPLE_BITS +: SAMPLE_BITS]),
    .out_ready (out_tready),
    .sts       (sts),
    .out_idx   (out_idx),
    .out_re    (out_re),
    .out_im    (out_im),
    .out_ovf   (out_tuser)
  );

  assign out_tvalid = sts.out_full;
  assign out_tdata  = OD_W'({out_im, out_re, out_idx});

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_tready) else $error("input taken while MAC busy");
  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !sts.done) else $error("done held for two cycles");
  a_report_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |-> !sts.out_full) else $error("report over pending result");
endmodule
`default_nettype wire

// ===== bench/convolution_peak_detector_test.sv =====
// Testbench for the convolution peak detector: streams directed and random frames and checks each peak report.
`default_nettype none
module convolution_peak_detector_test import cpd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class peak_scoreboard;
    typedef struct {
      logic [16:0] index;
      logic signed [29:0] re;
      logic signed [29:0] im;
      logic ovf;
    } peak_t;

    longint tap_re[64], tap_im[64];
    longint hist_re[64], hist_im[64];
    longint unsigned best_mag;
    longint best_re, best_im;
    int unsigned best_pos, out_pos, n_samples;
    bit dropped;
    int unsigned tap_count;
    peak_t peaks[$];
    int errors, reports;

    function new();
      tap_count = 64;
      errors = 0;
      reports = 0;
      for (int k = 0; k < 64; k++) begin
        tap_re[k] = 0;
        tap_im[k] = 0;
      end
      clear_frame();
    endfunction

    function void clear_frame();
      for (int k = 0; k < 64; k++) begin
        hist_re[k] = 0;
        hist_im[k] = 0;
      end
      best_mag = 0;
      best_re = 0;
      best_im = 0;
      best_pos = 0;
      out_pos = 0;
      n_samples = 0;
      dropped = 0;
    endfunction

    function int unsigned taps_used();
      if (tap_count < 1) return 1;
      if (tap_count > 64) return 64;
      return tap_count;
    endfunction

    function longint clamp30(longint v);
      if (v > 536870911) return 536870911;
      if (v < -536870912) return -536870912;
      return v;
    endfunction

    function void shift_in(longint re, longint im);
      longint acc_re, acc_im;
      longint unsigned mag;
      for (int k = 63; k > 0; k--) begin
        hist_re[k] = hist_re[k-1];
        hist_im[k] = hist_im[k-1];
      end
      hist_re[0] = re;
      hist_im[0] = im;
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < taps_used(); k++) begin
        acc_re += hist_re[k] * tap_re[k] - hist_im[k] * tap_im[k];
        acc_im += hist_re[k] * tap_im[k] + hist_im[k] * tap_re[k];
      end
      acc_re = clamp30(acc_re);
      acc_im = clamp30(acc_im);
      mag = longint'(acc_re * acc_re) + longint'(acc_im * acc_im);
      if (mag > best_mag) begin
        best_mag = mag;
        best_re = acc_re;
        best_im = acc_im;
        best_pos = out_pos;
      end
      out_pos++;
    endfunction

    function void note_input(logic cmd, logic [5:0] idx, logic signed [11:0] re,
                             logic signed [11:0] im, logic last);
      peak_t p;
      if (cmd == CMD_LOAD) begin
        tap_re[idx] = re;
        tap_im[idx] = im;
        return;
      end
      if (n_samples < 65536) begin
        n_samples++;
        shift_in(re, im);
      end else
        dropped = 1;
      if (!last) return;
      for (int k = 1; k < taps_used(); k++) shift_in(0, 0);
      p.index = best_pos[16:0];
      p.re = best_re[29:0];
      p.im = best_im[29:0];
      p.ovf = dropped;
      peaks = {peaks, p};
      clear_frame();
    endfunction

    function void check_result(logic [79:0] data, logic user);
      peak_t p;
      reports++;
      if (peaks.size() == 0) begin
        $error("unexpected peak report: %h", data);
        errors++;
        return;
      end
      p = peaks.pop_front();
      if (data[16:0] !== p.index) begin
        $error("peak_index: expected %0d, got %0d", p.index, data[16:0]);
        errors++;
      end
      if (data[46:17] !== p.re) begin
        $error("peak_re: expected %0d, got %0d", p.re, $signed(data[46:17]));
        errors++;
      end
      if (data[76:47] !== p.im) begin
        $error("peak_im: expected %0d, got %0d", p.im, $signed(data[76:47]));
        errors++;
      end
      if (user !== p.ovf) begin
        $error("overflow: expected %0d, got %0d", p.ovf, user);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 0, in_tuser = 0, in_tlast = 0;
  logic [31:0] in_tdata = '0;
  wire logic in_tready;
  wire logic out_tvalid, out_tuser;
  wire logic [79:0] out_tdata;
  logic out_tready = 0;

  peak_scoreboard sb = new();
  bit quiet = 0;
  int items = 0, frames = 0, idle_cycles = 0;

  convolution_peak_detector DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  initial forever #5 clk = ~clk;

  // receiver with bursts of stall
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
      out_tready <= 1;
    end else
      out_tready <= 1;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 30000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [5:0] idx, logic signed [11:0] re,
                           logic signed [11:0] im, logic last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tlast <= last;
    in_tdata <= {2'b00, im, re, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, idx, re, im, last);
    items++;
  endtask

  task automatic write_tap_count(logic [CFG_W-1:0] v);
    in_tvalid <= 0;
    wait (sb.peaks.size() == 0);
    repeat (100) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.tap_count = v;
  endtask

  function automatic logic signed [11:0] pick_value();
    case ($urandom_range(0, 7))
      0: return -12'sd2048;
      1: return 12'sd2047;
      2: return 12'sd0;
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic random_frame(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(CMD_LOAD, 6'($urandom), pick_value(), pick_value(), 1'($urandom));
      send_item(CMD_FEED, 6'($urandom), pick_value(), pick_value(), i == len - 1);
    end
    frames++;
  endtask

  initial begin
    logic [CFG_W-1:0] counts[] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd7, 7'd33, 7'd100};
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // saturating frame: every tap and sample at the negative extreme
    for (int k = 0; k < 64; k++)
      send_item(CMD_LOAD, 6'(k), -12'sd2048, -12'sd2048, 1'b0);
    for (int k = 0; k < 64; k++)
      send_item(CMD_FEED, 6'd0, -12'sd2048, -12'sd2048, k == 63);
    // all-zero output, then equal magnitudes to check the first peak wins
    send_item(CMD_FEED, 6'h3f, 12'sd0, 12'sd0, 1'b1);
    write_tap_count(7'd1);
    send_item(CMD_FEED, 6'd0, 12'sd2047, 12'sd0, 1'b0);
    send_item(CMD_FEED, 6'd0, 12'sd0, 12'sd2047, 1'b0);
    send_item(CMD_FEED, 6'd0, -12'sd2048, 12'sd2047, 1'b1);
    send_item(CMD_LOAD, 6'd0, 12'sd2047, 12'sd2047, 1'b0);
    send_item(CMD_FEED, 6'd0, 12'sd2047, -12'sd2048, 1'b1);
    frames += 4;
    phase = 0;
    while (items < 1900) begin
      write_tap_count(phase < counts.size() ? counts[phase]
                                            : CFG_W'($urandom_range(0, 127)));
      for (int f = 0; f < 4 && items < 1900; f++) begin
        if (items > 1650) quiet = 1;
        random_frame($urandom_range(0, 5) == 0 ? $urandom_range(60, 90)
                                               : $urandom_range(1, 24));
      end
      phase++;
    end
    in_tvalid <= 0;
    wait (sb.peaks.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d items in %0d frames over %0d tap_count settings, %0d reports",
             items, frames, phase + 1, sb.reports);
    $display("including saturation, zero output, ties and loads inside frames");
    if (sb.errors == 0 && sb.peaks.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
